FILE: hw/rtl/mexp_pkg.sv
// shared constants and types for the modular exponentiation core
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int BASE_W = 30;
  localparam int EXP_W = 63;
  localparam int EXP_BITS_DEFAULT = 63;
  localparam int IN_FIELDS_W = BASE_W + EXP_W;
  localparam int IN_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_W = ((BASE_W + 7) / 8) * 8;

  localparam int SUM_W = BASE_W + 2;
  localparam int MUL_STEPS = BASE_W;
  localparam int CNT_W = $clog2(MUL_STEPS);

  localparam logic [BASE_W-1:0] MODULUS = BASE_W'(1000000007);
  localparam logic [SUM_W-1:0] MOD_X1 = SUM_W'(1000000007);
  localparam logic [SUM_W-1:0] MOD_X2 = SUM_W'(2000000014);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/mexp_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module mexp_modmul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mexp_pkg::BASE_W-1:0]  x_in,
  input  logic [mexp_pkg::BASE_W-1:0]  y_in,
  output logic                         done,
  output logic [mexp_pkg::BASE_W-1:0]  prod
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [mexp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mexp_pkg::BASE_W-1:0]  x_r, x_nxt;
  logic [mexp_pkg::BASE_W-1:0]  y_r, y_nxt;
  logic [mexp_pkg::BASE_W-1:0]  acc_r, acc_nxt;
  logic [mexp_pkg::SUM_W-1:0]   sum;
  logic [mexp_pkg::SUM_W-1:0]   sum_m1;
  logic [mexp_pkg::SUM_W-1:0]   sum_m2;
  logic [mexp_pkg::SUM_W-1:0]   red;

  // acc stays below the modulus, so 2*acc + x stays below three times it
  always_comb begin
    sum = {1'b0, acc_r, 1'b0}
          + (y_r[mexp_pkg::BASE_W-1] ? {2'b00, x_r} : '0);
    sum_m1 = sum - mexp_pkg::MOD_X1;
    sum_m2 = sum - mexp_pkg::MOD_X2;
    if (sum >= mexp_pkg::MOD_X2) begin
      red = sum_m2;
    end else if (sum >= mexp_pkg::MOD_X1) begin
      red = sum_m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mexp_pkg::CNT_W'(mexp_pkg::MUL_STEPS - 1);
      x_nxt    = x_in;
      y_nxt    = y_in;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = red[mexp_pkg::BASE_W-1:0];
      y_nxt   = {y_r[mexp_pkg::BASE_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: hw/rtl/modular_exponentiation_core.sv
// top level: right-to-left square-and-multiply modulo 1000000007
//
//   port group | dir | word contents
//   in_        | in  | base_value [29:0], exponent_value [92:30]
//   out_       | out | power_result [29:0]
//
// one word at a time; each exponent bit takes one pass of the
// bit-serial modular multipliers (square and multiply run side by side)
// per word: ST_CHECK and ST_WAIT repeat once per exponent bit, then ST_FINISH
// the scan stops as soon as the remaining exponent bits are all zero
// a new word is taken while a finished result waits in the output register
// synchronous active-low reset clears control state only
`timescale 1ns / 1ps

module modular_exponentiation_core #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mexp_pkg::IN_W-1:0]  in_tdata,   // base_value, exponent_value, zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mexp_pkg::OUT_W-1:0] out_tdata   // power_result, zero pad
);

  localparam int BW = mexp_pkg::BASE_W;

  mexp_pkg::state_t state_r, state_nxt;
  logic [BW-1:0]        power_r, power_nxt;
  logic [BW-1:0]        acc_r, acc_nxt;
  logic [EXP_BITS-1:0]  exp_r, exp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BW-1:0]        out_data_r, out_data_nxt;
  logic [BW-1:0]        base_in;
  logic [BW-1:0]        base_red;
  logic                 mul_start;
  logic                 sq_done, ml_done;
  logic [BW-1:0]        sq_prod, ml_prod;

  assign base_in  = in_tdata[BW-1:0];
  assign base_red = (base_in >= mexp_pkg::MODULUS) ? (base_in - mexp_pkg::MODULUS) : base_in;

  assign in_tready = (state_r == mexp_pkg::ST_IDLE);

  mexp_modmul u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x_in  (power_r),
    .y_in  (power_r),
    .done  (sq_done),
    .prod  (sq_prod)
  );

  mexp_modmul u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x_in  (acc_r),
    .y_in  (power_r),
    .done  (ml_done),
    .prod  (ml_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    power_nxt     = power_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          power_nxt = base_red;
          acc_nxt   = BW'(1);
          exp_nxt   = in_tdata[BW +: EXP_BITS];
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = mexp_pkg::ST_FINISH;
        end else begin
          mul_start = 1'b1;
          state_nxt = mexp_pkg::ST_WAIT;
        end
      end
      mexp_pkg::ST_WAIT: begin
        if (sq_done && ml_done) begin
          power_nxt = sq_prod;
          if (exp_r[0]) begin
            acc_nxt = ml_prod;
          end
          exp_nxt   = exp_r >> 1;
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    power_r    <= power_nxt;
    acc_r      <= acc_nxt;
    exp_r      <= exp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mexp_pkg::OUT_W - BW){1'b0}}, out_data_r};

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the modular exponentiation core
`timescale 1ns / 1ps

module testbench;

  localparam int BASE_W = mexp_pkg::BASE_W;
  localparam int EXP_W = mexp_pkg::EXP_W;
  localparam int IN_W = mexp_pkg::IN_W;
  localparam int OUT_W = mexp_pkg::OUT_W;
  localparam int IN_FIELDS_W = mexp_pkg::IN_FIELDS_W;
  localparam logic [BASE_W-1:0] MODULUS = mexp_pkg::MODULUS;

  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(1000000006);
  localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};
  localparam int HOLD_LEN = 800;
  localparam int DRAIN_CYCLES = 2200;
  localparam int CYCLE_LIMIT = 10_000_000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_HOLD
  } rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  logic [BASE_W-1:0] expected_powers[$];
  logic [BASE_W-1:0] want_power;
  int                errors = 0;
  int                cycle_count = 0;
  int                hold_cnt = 0;
  int                burst_left = 0;
  bit                paced = 0;
  rx_mode_t          rx_mode = RX_ALWAYS;
  logic [15:0]       stall_pat = 16'b1011_0111_0010_1110;

  modular_exponentiation_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // right-to-left square-and-multiply modulo the prime
  function automatic logic [BASE_W-1:0] mod_power(logic [BASE_W-1:0] b,
                                                  logic [EXP_W-1:0] e);
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] m;
    m = 64'(MODULUS);
    sq = 64'(b) % m;
    acc = 64'd1;
    for (int k = 0; k < EXP_W; k++) begin
      if (e[k]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[BASE_W-1:0];
  endfunction

  // mostly short exponents, a few full width
  function automatic logic [EXP_W-1:0] random_exponent();
    logic [63:0] raw;
    int          w;
    int          pick;
    raw = {$urandom, $urandom};
    pick = $urandom_range(99, 0);
    if (pick < 5) w = EXP_W;
    else if (pick < 20) w = $urandom_range(32, 13);
    else w = $urandom_range(12, 0);
    return EXP_W'(raw & ((64'd1 << w) - 64'd1));
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    int pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return '0;
    if (pick == 1) return BASE_W'(1);
    if (pick == 2) return BASE_MAX;
    return BASE_W'($urandom_range(1000000006, 0));
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side ready pattern
  always @(posedge clk) begin
    if (rx_mode == RX_HOLD) begin
      out_tready <= (hold_cnt >= HOLD_LEN);
      if (hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
    end else begin
      hold_cnt <= 0;
      case (rx_mode)
        RX_RANDOM: begin
          out_tready <= ($urandom_range(3, 0) != 0);
        end
        RX_PATTERN: begin
          out_tready <= stall_pat[0];
          stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
        default: begin
          out_tready <= 1'b1;
        end
      endcase
    end
  end

  // predict on input words, check result words
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_powers.size() == 0) begin
        $error("unexpected word, power_result %0d", out_tdata[BASE_W-1:0]);
        errors++;
      end else begin
        want_power = expected_powers.pop_front();
        if (out_tdata[BASE_W-1:0] !== want_power) begin
          $error("power_result: expected %0d, actual %0d", want_power, out_tdata[BASE_W-1:0]);
          errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      expected_powers = {expected_powers,
                         mod_power(in_tdata[BASE_W-1:0], in_tdata[IN_FIELDS_W-1:BASE_W])};
  end

  task automatic send_word(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        gap = $urandom_range(40, 1);
        burst_left = $urandom_range(12, 1);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_tdata <= IN_W'({e, b});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_results();
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    paced = 0;
    rx_mode <= RX_ALWAYS;
    send_word('0, '0);
    send_word(BASE_MAX, '0);
    send_word(BASE_W'(1), '0);
    send_word('0, EXP_W'(1));
    send_word('0, EXP_MAX);
    send_word(BASE_W'(1), EXP_MAX);
    send_word(BASE_MAX, EXP_MAX);
    send_word(BASE_MAX, EXP_W'(1));
    send_word(BASE_MAX, EXP_W'(2));
    send_word(BASE_MAX, EXP_W'(3));
    send_word(BASE_W'(2), EXP_W'(1) << (EXP_W - 1));
    send_word(BASE_W'(2), EXP_W'(1000000006));
    send_word(BASE_W'(3), EXP_W'(1000000005));
    send_word(30'h1555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_word(30'h2AAA_AAAA, 63'h5555_5555_5555_5555);
    send_word(30'h2000_0000, EXP_MAX);
    send_word(BASE_W'(12345), EXP_W'(1));
    in_tvalid <= 1'b0;
    wait_results();
  endtask

  // receiver holds off long enough for the core to fill and stall its input
  task automatic test_output_hold_off();
    paced = 0;
    rx_mode <= RX_HOLD;
    for (int n = 0; n < 30; n++)
      send_word(random_base(), EXP_W'($urandom_range(15, 0)));
    in_tvalid <= 1'b0;
    wait_results();
    rx_mode <= RX_ALWAYS;
  endtask

  task automatic test_random_powers();
    for (int n = 0; n < 700; n++) begin
      if (n % 100 == 0) begin
        case ((n / 100) % 4)
          0: begin paced = 1; rx_mode <= RX_RANDOM; end
          1: begin paced = 1; rx_mode <= RX_PATTERN; end
          2: begin paced = 0; rx_mode <= RX_ALWAYS; end
          default: begin paced = 0; rx_mode <= RX_RANDOM; end
        endcase
      end
      send_word(random_base(), random_exponent());
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_hold_off();
    test_random_powers();
    rx_mode <= RX_ALWAYS;
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
